>>> rtl/pprs_pkg.sv
`timescale 1ns / 1ps
package pprs_pkg;
    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    localparam logic [7:0] QUANTUM_RESET = 8'd4;
    localparam logic [0:0] REG_QUANTUM   = 1'b0;

    // controller -> datapath
    typedef struct packed {
        logic clear_scan;   // start a minimum search
        logic scan_step;    // examine one store slot
        logic do_arrive;    // write arrival into the free slot
        logic do_decide;    // apply the scheduling decision
        logic do_exec;      // run one time unit
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;    // current slot is the last one
    } t_dp_sts;
endpackage

>>> rtl/preemptive_priority_rr_scheduler_top.sv
`timescale 1ns / 1ps
// After acceptance the task store is scanned one slot per cycle, then the item is
// inserted (arrive) or the scheduling decision applied (tick), followed by an
// execute step on ticks; the result is held until taken. One item at a time: a new
// item is accepted only after the previous result has been taken.
// Reset (synchronous, active low) empties store, FIFO and CPU; quantum = 4.
module preemptive_priority_rr_scheduler_top
    import pprs_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_task_id,
    input  logic [15:0] i_burst_length,
    input  logic [7:0]  i_task_priority,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_running_valid,
    output logic [7:0]  o_running_id,
    output logic        o_finished,
    output logic        o_sliced,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_dp_cmd    w_cmd;
    t_dp_sts    w_sts;
    logic [7:0] r_quantum;

    // Single register: quantum at address 0.
    assign pready = 1'b1;
    assign prdata = (paddr == REG_QUANTUM) ? {24'd0, r_quantum} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QUANTUM_RESET;
        end else if (psel && penable && pwrite && paddr == REG_QUANTUM) begin
            r_quantum <= pwdata[7:0];
        end
    end

    pprs_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_opcode,
        .o_out_valid, .i_out_ready, .o_cmd(w_cmd), .i_sts(w_sts)
    );

    pprs_datapath #(.MAX_TASKS(MAX_TASKS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts), .i_quantum(r_quantum),
        .i_task_id, .i_burst_length, .i_task_priority, .o_status,
        .o_running_valid, .o_running_id, .o_finished, .o_sliced
    );
endmodule

>>> rtl/pprs_datapath.sv
`timescale 1ns / 1ps
module pprs_datapath
    import pprs_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic [7:0]  i_quantum,
    input  logic [7:0]  i_task_id,
    input  logic [15:0] i_burst_length,
    input  logic [7:0]  i_task_priority,
    output logic [1:0]  o_status,
    output logic        o_running_valid,
    output logic [7:0]  o_running_id,
    output logic        o_finished,
    output logic        o_sliced
);
    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [AW-1:0] LAST = AW'(MAX_TASKS - 1);

    logic [MAX_TASKS-1:0] r_svalid;
    logic [7:0]  r_sid  [MAX_TASKS];
    logic [15:0] r_srem [MAX_TASKS];
    logic [7:0]  r_sprio[MAX_TASKS];
    logic [7:0]  r_fid  [MAX_TASKS];
    logic [15:0] r_frem [MAX_TASKS];
    logic [7:0]  r_fprio[MAX_TASKS];

    logic [AW-1:0] r_head, r_tail, r_idx, r_best, r_free;
    logic [CW-1:0] r_fcount, r_present;
    logic          r_found, r_free_ok;
    logic [7:0]    r_bid, r_bprio;
    logic [15:0]   r_brem;
    logic          r_cvalid, r_cfifo;
    logic [7:0]    r_cid, r_cprio, r_qleft;
    logic [15:0]   r_crem;
    logic [7:0]    r_in_id, r_in_prio;
    logic [15:0]   r_in_burst;

    logic [7:0] w_q;
    logic       w_better;
    assign w_q = (i_quantum == 8'd0) ? 8'd1 : i_quantum;
    assign o_sts.scan_last = (r_idx == LAST);

    assign w_better = r_svalid[r_idx] && (!r_found || r_sprio[r_idx] < r_bprio ||
        (r_sprio[r_idx] == r_bprio && r_sid[r_idx] < r_bid));

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_svalid <= '0; r_head <= '0; r_tail <= '0; r_fcount <= '0;
            r_present <= '0; r_cvalid <= 1'b0; r_cfifo <= 1'b0; r_cid <= '0;
            r_cprio <= '0; r_crem <= '0; r_qleft <= '0; r_idx <= '0;
            r_found <= 1'b0; r_free_ok <= 1'b0; r_best <= '0; r_free <= '0;
            r_bid <= '0; r_bprio <= '0; r_brem <= '0;
            r_in_id <= '0; r_in_burst <= '0; r_in_prio <= '0;
            o_status <= ST_OK; o_running_valid <= 1'b0; o_running_id <= '0;
            o_finished <= 1'b0; o_sliced <= 1'b0;
        end else begin
            if (i_cmd.clear_scan) begin
                r_idx <= '0; r_found <= 1'b0; r_free_ok <= 1'b0;
                // hold the accepted item's fields for the insert
                r_in_id <= i_task_id; r_in_burst <= i_burst_length;
                r_in_prio <= i_task_priority;
            end
            if (i_cmd.scan_step) begin
                if (w_better) begin
                    r_found <= 1'b1; r_best <= r_idx; r_bid <= r_sid[r_idx];
                    r_bprio <= r_sprio[r_idx]; r_brem <= r_srem[r_idx];
                end
                if (!r_svalid[r_idx] && !r_free_ok) begin
                    r_free_ok <= 1'b1; r_free <= r_idx;
                end
                if (r_idx != LAST) r_idx <= r_idx + AW'(1);
            end
            if (i_cmd.do_arrive) begin
                o_running_valid <= 1'b0; o_running_id <= '0;
                o_finished <= 1'b0; o_sliced <= 1'b0;
                if (r_in_burst == 16'd0) o_status <= ST_ZERO;
                else if (r_present >= CW'(MAX_TASKS) || !r_free_ok) o_status <= ST_FULL;
                else begin
                    o_status <= ST_OK;
                    r_svalid[r_free] <= 1'b1; r_sid[r_free] <= r_in_id;
                    r_srem[r_free] <= r_in_burst; r_sprio[r_free] <= r_in_prio;
                    r_present <= r_present + CW'(1);
                end
            end
            if (i_cmd.do_decide) begin
                if (!r_cvalid) begin
                    if (r_found) begin
                        r_cvalid <= 1'b1; r_cid <= r_bid; r_crem <= r_brem;
                        r_cprio <= r_bprio; r_cfifo <= 1'b0; r_svalid[r_best] <= 1'b0;
                        r_qleft <= w_q;
                    end else if (r_fcount != '0) begin
                        r_cvalid <= 1'b1; r_cid <= r_fid[r_head];
                        r_crem <= r_frem[r_head]; r_cprio <= r_fprio[r_head];
                        r_cfifo <= 1'b1; r_head <= inc(r_head);
                        r_fcount <= r_fcount - CW'(1); r_qleft <= w_q;
                    end
                end else if (r_found && (r_cfifo || r_bprio < r_cprio)) begin
                    // preempt: push current, take best (FIFO bounded by present count)
                    r_fid[r_tail] <= r_cid; r_frem[r_tail] <= r_crem;
                    r_fprio[r_tail] <= r_cprio; r_tail <= inc(r_tail);
                    r_fcount <= r_fcount + CW'(1);
                    r_cid <= r_bid; r_crem <= r_brem; r_cprio <= r_bprio;
                    r_cfifo <= 1'b0; r_svalid[r_best] <= 1'b0; r_qleft <= w_q;
                end
            end
            if (i_cmd.do_exec) begin
                o_status <= ST_OK;
                o_running_valid <= r_cvalid;
                o_running_id <= r_cvalid ? r_cid : 8'd0;
                o_finished <= r_cvalid && (r_crem == 16'd1);
                o_sliced <= r_cvalid && (r_crem != 16'd1) && (r_qleft == 8'd1);
                if (r_cvalid) begin
                    r_crem <= r_crem - 16'd1; r_qleft <= r_qleft - 8'd1;
                    if (r_crem == 16'd1) begin
                        r_cvalid <= 1'b0;
                        if (r_present != '0) r_present <= r_present - CW'(1);
                    end else if (r_qleft == 8'd1) begin
                        r_cvalid <= 1'b0;
                        r_fid[r_tail] <= r_cid; r_frem[r_tail] <= r_crem - 16'd1;
                        r_fprio[r_tail] <= r_cprio; r_tail <= inc(r_tail);
                        r_fcount <= r_fcount + CW'(1);
                    end
                end
            end
        end
    end

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcount <= r_present) else $error("fifo count exceeds tasks present");
    a_fin_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_finished && o_sliced)) else $error("finished and sliced together");
    a_run_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_running_valid |-> (o_running_id == 8'd0 && !o_finished))
        else $error("idle result carries task data");
endmodule

>>> rtl/pprs_ctrl.sv
`timescale 1ns / 1ps
module pprs_ctrl
    import pprs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_opcode,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);
    localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_APPLY = 3'd2,
                           S_EXEC = 3'd3, S_OUT = 3'd4;
    logic [2:0] r_state, n_state;
    logic       r_op;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.clear_scan = 1'b1; n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_state = S_APPLY;
            end
            S_APPLY: begin
                if (r_op == OP_ARRIVE) begin
                    o_cmd.do_arrive = 1'b1; n_state = S_OUT;
                end else begin
                    o_cmd.do_decide = 1'b1; n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.do_exec = 1'b1; n_state = S_OUT;
            end
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_op <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_in_valid) r_op <= i_opcode;
        end
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.scan_step, o_cmd.do_arrive, o_cmd.do_decide, o_cmd.do_exec}))
        else $error("overlapping datapath commands");
    a_exec_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.do_decide |=> o_cmd.do_exec) else $error("decide not followed by exec");
endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import pprs_pkg::*;

    localparam int STORE_DEPTH  = 16;
    localparam int DRAIN_CYCLES = STORE_DEPTH + 8;   // a bit more than one item's latency
    localparam int STALL_LIMIT  = 5000;              // cycles with no handshake at all
    localparam int HOLD_CYCLES  = 400;               // long receiver hold-off

    typedef struct packed {
        logic [1:0] status;
        logic       run_valid;
        logic [7:0] run_id;
        logic       done;
        logic       slice;
    } sched_result_t;

    // Scheduler shadow: tracks store, round-robin queue and CPU, and keeps the
    // results the block owes us in order.
    class sched_scoreboard;
        bit         slot_used[STORE_DEPTH];
        bit [7:0]   slot_id[STORE_DEPTH];
        bit [15:0]  slot_left[STORE_DEPTH];
        bit [7:0]   slot_prio[STORE_DEPTH];
        bit [7:0]   rr_id[STORE_DEPTH];
        bit [15:0]  rr_left[STORE_DEPTH];
        bit [7:0]   rr_prio[STORE_DEPTH];
        int         rr_head, rr_tail, rr_count, live_tasks;
        bit         cpu_busy, cpu_from_rr;
        bit [7:0]   cpu_id, cpu_prio, slice_left, quantum;
        bit [15:0]  cpu_left;
        sched_result_t owed_q[$];
        int errors, results_seen, finishes, slices, rejects;

        function new();
            quantum = QUANTUM_RESET;
        endfunction

        task report(input string what);
            errors++;
            $display("MISMATCH @%0t: %s", $time, what);
        endtask

        function bit [7:0] fresh_slice();
            return (quantum == 8'd0) ? 8'd1 : quantum;
        endfunction

        function int best_slot();
            int pick;
            pick = -1;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                if (!slot_used[i]) continue;
                if (pick < 0 || slot_prio[i] < slot_prio[pick] ||
                    (slot_prio[i] == slot_prio[pick] && slot_id[i] < slot_id[pick]))
                    pick = i;
            end
            return pick;
        endfunction

        function void park_cpu_task();
            if (rr_count >= STORE_DEPTH) return;
            rr_id[rr_tail]   = cpu_id;
            rr_left[rr_tail] = cpu_left;
            rr_prio[rr_tail] = cpu_prio;
            rr_tail = (rr_tail + 1) % STORE_DEPTH;
            rr_count++;
        endfunction

        function void load_slot(input int s);
            cpu_busy = 1; cpu_from_rr = 0;
            cpu_id = slot_id[s]; cpu_left = slot_left[s]; cpu_prio = slot_prio[s];
            slot_used[s] = 0;
            slice_left = fresh_slice();
        endfunction

        function void load_rr_head();
            cpu_busy = 1; cpu_from_rr = 1;
            cpu_id = rr_id[rr_head]; cpu_left = rr_left[rr_head];
            cpu_prio = rr_prio[rr_head];
            rr_head = (rr_head + 1) % STORE_DEPTH;
            rr_count--;
            slice_left = fresh_slice();
        endfunction

        function void note_item(input logic op, input logic [7:0] id,
                                input logic [15:0] burst, input logic [7:0] prio);
            sched_result_t r;
            int pick;
            bit placed;
            r = '0;
            if (op == OP_ARRIVE) begin
                if (burst == 16'd0) r.status = ST_ZERO;
                else if (live_tasks >= STORE_DEPTH) r.status = ST_FULL;
                else begin
                    placed = 0;
                    for (int i = 0; i < STORE_DEPTH && !placed; i++) begin
                        if (!slot_used[i]) begin
                            slot_used[i] = 1; slot_id[i] = id;
                            slot_left[i] = burst; slot_prio[i] = prio;
                            live_tasks++;
                            placed = 1;
                        end
                    end
                    if (!placed) r.status = ST_FULL;
                end
                if (r.status != ST_OK) rejects++;
            end else begin
                pick = best_slot();
                if (!cpu_busy) begin
                    if (pick >= 0) load_slot(pick);
                    else if (rr_count > 0) load_rr_head();
                end else if (pick >= 0 && (cpu_from_rr || slot_prio[pick] < cpu_prio)) begin
                    park_cpu_task();
                    load_slot(pick);
                end
                if (cpu_busy) begin
                    r.run_valid = 1;
                    r.run_id = cpu_id;
                    cpu_left--;
                    slice_left--;
                    if (cpu_left == 16'd0) begin
                        r.done = 1; cpu_busy = 0; finishes++;
                        if (live_tasks > 0) live_tasks--;
                    end else if (slice_left == 8'd0) begin
                        r.slice = 1; slices++;
                        park_cpu_task();
                        cpu_busy = 0;
                    end
                end
            end
            owed_q = {owed_q, r};
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        task check_result(input sched_result_t got);
            sched_result_t want;
            results_seen++;
            if (owed_q.size() == 0) begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            want = owed_q.pop_front();
            if (got.status != want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.run_valid != want.run_valid)
                report($sformatf("running_valid got %0b want %0b",
                                 got.run_valid, want.run_valid));
            if (got.run_id != want.run_id)
                report($sformatf("running_id got %0d want %0d", got.run_id, want.run_id));
            if (got.done != want.done)
                report($sformatf("finished got %0b want %0b", got.done, want.done));
            if (got.slice != want.slice)
                report($sformatf("sliced got %0b want %0b", got.slice, want.slice));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_opcode = OP_TICK;
    logic [7:0]  i_task_id = '0;
    logic [15:0] i_burst_length = '0;
    logic [7:0]  i_task_priority = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic        o_running_valid;
    logic [7:0]  o_running_id;
    logic        o_finished;
    logic        o_sliced;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sched_scoreboard sb = new();
    bit idling_on = 1'b1;   // random gaps on both sides
    bit hold_req  = 1'b0;   // ask the receiver for one long hold-off
    int quiet_cycles = 0;

    preemptive_priority_rr_scheduler_top #(.MAX_TASKS(STORE_DEPTH)) dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Sample both channels at the rising edge; retire results before noting
    // the new item so the order of the two never matters.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result({o_status, o_running_valid, o_running_id, o_finished, o_sliced});
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_item(i_opcode, i_task_id, i_burst_length, i_task_priority);
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("testbench: errors");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, none at the end.
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                n = $urandom_range(1, 18);
                repeat (n) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
                // stretch of free flow
                if ($urandom_range(0, 3) == 0) begin
                    n = $urandom_range(1, 40);
                    repeat (n) @(negedge i_clk);
                end
            end
        end
    end

    // Offer one item; valid stays high until the block takes it. Call at a
    // falling edge, return at the next falling edge after acceptance.
    task send_item(input logic op, input logic [7:0] id, input logic [15:0] burst,
                   input logic [7:0] prio);
        int gap;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_task_id <= id;
        i_burst_length <= burst;
        i_task_priority <= prio;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task arrive(input logic [7:0] id, input logic [15:0] burst, input logic [7:0] prio);
        send_item(OP_ARRIVE, id, burst, prio);
    endtask

    task tick();
        send_item(OP_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // Wait until the block owes nothing, let it settle, then write the quantum.
    task set_quantum(input logic [7:0] q);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= REG_QUANTUM; pwdata <= {24'd0, q};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.quantum = q;
    endtask

    // One random item: mostly a plausible arrive/tick mix with short bursts
    // and crowded priorities, so ties, preemption and slicing come up often.
    task random_item();
        int r;
        logic [7:0]  id, prio;
        logic [15:0] burst;
        r = $urandom_range(0, 99);
        id = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        prio = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        if ($urandom_range(0, 19) < 16) burst = 16'($urandom_range(1, 12));
        else burst = 16'($urandom_range(13, 300));
        if (r < 3) arrive(id, 16'd0, prio);
        else if (r < 38) arrive(id, burst, prio);
        else tick();
    endtask

    initial begin
        logic [7:0] phase_q[6];
        phase_q = '{8'd1, 8'd0, 8'd255, 8'($urandom_range(2, 254)), 8'd2, 8'd3};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: idle tick, field extremes, rejects, equal tasks, a full store.
        tick();
        arrive(8'd255, 16'd0, 8'd255);
        arrive(8'd255, 16'd3, 8'd255);
        arrive(8'd0, 16'd1, 8'd0);
        arrive(8'd7, 16'd2, 8'd9);
        arrive(8'd7, 16'd2, 8'd9);
        repeat (3) tick();
        for (int i = 0; i < STORE_DEPTH; i++)
            arrive(8'(i * 17), 16'($urandom_range(1, 5)), 8'($urandom_range(0, 3)));
        arrive(8'd255, 16'hFFFF, 8'd255);   // store full, wide burst rejected
        arrive(8'd128, 16'h8000, 8'd128);
        for (int i = 0; i < 60; i++) tick();

        // Random phases under different quantum settings; the last runs without gaps.
        foreach (phase_q[p]) begin
            set_quantum(phase_q[p]);
            if (p == 5) idling_on = 1'b0;
            for (int i = 0; i < 290; i++) begin
                if (p == 2 && i == 100) hold_req = 1'b1;
                random_item();
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d results: %0d finished, %0d sliced, %0d arrivals rejected",
                 sb.results_seen, sb.finishes, sb.slices, sb.rejects);
        $display("quantum settings 4, 1, 0, 255 and others; one long output hold-off");
        if (sb.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

>>> filelist.f
rtl/pprs_pkg.sv
rtl/pprs_datapath.sv
rtl/pprs_ctrl.sv
rtl/preemptive_priority_rr_scheduler_top.sv
test/testbench.sv
